@@ hdl/iqsc_pkg.sv @@
// Package with shared types and constants of the I/O queue statistics counter.
`default_nettype none
package iqsc_pkg;

   localparam int TimeWidth  = 63;
   localparam int StatWidth  = 64;
   localparam int FileWidth  = 16;
   localparam int JobsWidth  = 32;
   localparam int BytesWidth = 48;
   localparam int SelWidth   = 6;

   typedef enum logic [1:0] {
      OP_FILES  = 2'd0,
      OP_POST   = 2'd1,
      OP_FINISH = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   localparam logic [SelWidth-1:0] SEL_FILES_PEAK = 6'd0;
   localparam logic [SelWidth-1:0] SEL_JOBS_PEAK  = 6'd1;
   localparam logic [SelWidth-1:0] SEL_BYTES_PEAK = 6'd2;
   localparam logic [SelWidth-1:0] SEL_WRITES     = 6'd3;
   localparam logic [SelWidth-1:0] SEL_BORROWED   = 6'd4;
   localparam logic [SelWidth-1:0] SEL_COPIED     = 6'd5;
   localparam logic [SelWidth-1:0] SEL_WAIT_MAX   = 6'd6;
   localparam logic [SelWidth-1:0] SEL_RUN_MAX    = 6'd7;
   localparam logic [SelWidth-1:0] SEL_FILES_MEAN = 6'd8;
   localparam logic [SelWidth-1:0] SEL_WAIT_MEAN  = 6'd9;
   localparam logic [SelWidth-1:0] SEL_RUN_MEAN   = 6'd10;
   localparam logic [SelWidth-1:0] SEL_HIST_BASE  = 6'd11;

   // One classified event, as handed from the front end to the back end.
   typedef struct packed {
      opcode_type                op;
      logic [TimeWidth-1:0]      now;
      logic [FileWidth-1:0]      files;
      logic [JobsWidth-1:0]      jobs;
      logic [BytesWidth-1:0]     bytes;
      logic [BytesWidth-1:0]     nbytes;
      logic                      nonempty;
      logic                      borrowed;
      logic [TimeWidth-1:0]      wait_ns;
      logic [TimeWidth-1:0]      run_ns;
      logic [SelWidth-1:0]       sel;
   } event_type;

   function automatic logic [StatWidth-1:0] sat_add(input logic [StatWidth-1:0] a,
                                                    input logic [StatWidth-1:0] b);
      logic [StatWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[StatWidth] ? {StatWidth{1'b1}} : s[StatWidth-1:0];
   endfunction

   function automatic logic [TimeWidth-1:0] span(input logic [TimeWidth-1:0] from,
                                                 input logic [TimeWidth-1:0] to);
      return (to > from) ? to - from : '0;
   endfunction

endpackage
`default_nettype wire

@@ hdl/io_queue_statistics_counter_unit.sv @@
// Top level of the I/O queue statistics counter.
`default_nettype none
// The unit keeps statistics of an I/O write queue: peaks of files, jobs and
// bytes waiting, a time-weighted file integral, a log2 request size histogram,
// borrowed and copied byte totals, and wait and run time totals and maxima.
// Event words enter through a queue-style port (push/full) and are held in a
// two-word queue; the back end applies them one at a time. A file count update
// passes through a fold step, a posted write through a histogram read and, for a
// nonempty request, a write-back, and a finished write is applied when taken. A
// read passes through a fold and a read step; a mean with a nonzero divisor then
// waits for a one-bit-per-cycle divider (MEAN_FRAC_BITS fraction bits for the file mean).
// Results leave through a two-word queue (empty/pop).
// After reset the histogram memory is cleared bucket by bucket, during which
// no word is applied; words may still be pushed into the input queue.
module io_queue_statistics_counter_unit #(
   parameter int HIST_BUCKETS   = 32,
   parameter int MEAN_FRAC_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire logic [1:0]                      req_opcode,
   input  wire logic [iqsc_pkg::TimeWidth-1:0]  req_now_ns,
   input  wire logic [iqsc_pkg::FileWidth-1:0]  req_file_count,
   input  wire logic [iqsc_pkg::JobsWidth-1:0]  req_jobs_count,
   input  wire logic [iqsc_pkg::BytesWidth-1:0] req_bytes_count,
   input  wire logic [iqsc_pkg::BytesWidth-1:0] req_request_bytes,
   input  wire logic                            req_borrowed,
   input  wire logic [iqsc_pkg::TimeWidth-1:0]  req_posted_at,
   input  wire logic [iqsc_pkg::TimeWidth-1:0]  req_started_at,
   input  wire logic [iqsc_pkg::TimeWidth-1:0]  req_finished_at,
   input  wire logic [iqsc_pkg::SelWidth-1:0]   req_stat_select,
   output logic                                 empty,
   input  wire logic                            pop,
   output logic [iqsc_pkg::StatWidth-1:0]       rsp_stat_value
);
   import iqsc_pkg::*;

   logic      ev_valid, ev_take;
   event_type ev_data;

   iqsc_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .opcode(req_opcode), .now_ns(req_now_ns), .file_count(req_file_count),
      .jobs_count(req_jobs_count), .bytes_count(req_bytes_count),
      .request_bytes(req_request_bytes), .borrowed(req_borrowed),
      .posted_at(req_posted_at), .started_at(req_started_at),
      .finished_at(req_finished_at), .stat_select(req_stat_select),
      .ev_valid(ev_valid), .ev_data(ev_data), .ev_take(ev_take)
   );

   iqsc_back #(.SizeBuckets(HIST_BUCKETS), .MeanFracBits(MEAN_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .ev_valid(ev_valid), .ev_data(ev_data),
      .ev_take(ev_take), .empty(empty), .pop(pop), .stat_value(rsp_stat_value)
   );
endmodule
`default_nettype wire

@@ hdl/iqsc_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
`default_nettype none
module iqsc_ram #(
   parameter int Width = 64,
   parameter int Depth = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data_ff
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/iqsc_front.sv @@
// Front end: accepts event words, works out time spans and queues them.
`default_nettype none
module iqsc_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [1:0]                     opcode,
   input  wire logic [iqsc_pkg::TimeWidth-1:0] now_ns,
   input  wire logic [iqsc_pkg::FileWidth-1:0] file_count,
   input  wire logic [iqsc_pkg::JobsWidth-1:0] jobs_count,
   input  wire logic [iqsc_pkg::BytesWidth-1:0] bytes_count,
   input  wire logic [iqsc_pkg::BytesWidth-1:0] request_bytes,
   input  wire logic                           borrowed,
   input  wire logic [iqsc_pkg::TimeWidth-1:0] posted_at,
   input  wire logic [iqsc_pkg::TimeWidth-1:0] started_at,
   input  wire logic [iqsc_pkg::TimeWidth-1:0] finished_at,
   input  wire logic [iqsc_pkg::SelWidth-1:0]  stat_select,
   output logic                                ev_valid,
   output iqsc_pkg::event_type                 ev_data,
   input  wire logic                           ev_take
);
   import iqsc_pkg::*;

   // Two-entry queue between the front and the back end.
   event_type  q_ff [2];
   event_type  q_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign ev_valid = (cnt_ff != 2'd0);
   assign ev_data  = q_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = ev_take && ev_valid;

   always_comb begin
      q_in.op       = opcode_type'(opcode);
      q_in.now      = now_ns;
      q_in.files    = file_count;
      q_in.jobs     = jobs_count;
      q_in.bytes    = bytes_count;
      q_in.nbytes   = request_bytes;
      q_in.nonempty = (request_bytes != '0);
      q_in.borrowed = borrowed;
      q_in.wait_ns  = span(posted_at, started_at);
      q_in.run_ns   = span(started_at, finished_at);
      q_in.sel      = stat_select;
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/iqsc_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle, saturating quotient.
`default_nettype none
module iqsc_divider #(
   parameter int FracBits = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [iqsc_pkg::StatWidth-1:0]  num,
   input  wire logic [iqsc_pkg::StatWidth-1:0]  den,
   output logic                                 done,
   output logic      [iqsc_pkg::StatWidth-1:0]  quot
);
   import iqsc_pkg::*;

   // The numerator is scaled by 2^FracBits; quotient bits above the result
   // width only mark saturation.
   localparam int NumWidth = StatWidth + FracBits;
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0]  num_ff, num_in;
   logic [NumWidth-1:0]  q_ff, q_in;
   logic [StatWidth:0]   rem_ff, rem_in;
   logic [StatWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [StatWidth:0]   trial;
   logic                 fits;

   assign done = done_ff;

   if (FracBits > 0) begin : g_sat
      assign quot = (q_ff[NumWidth-1:StatWidth] != '0) ? {StatWidth{1'b1}}
                                                       : q_ff[StatWidth-1:0];
   end else begin : g_plain
      assign quot = q_ff[StatWidth-1:0];
   end

   always_comb begin
      trial  = {rem_ff[StatWidth-1:0], num_ff[NumWidth-1]};
      fits   = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      q_in   = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = NumWidth'(num) << FracBits;
         q_in    = '0;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NumWidth-2:0], 1'b0};
         rem_in = fits ? trial - {1'b0, den_ff} : trial;
         q_in   = {q_ff[NumWidth-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/iqsc_back.sv @@
// Back end: keeps the statistics, runs reads and holds the result queue.
`default_nettype none
module iqsc_back #(
   parameter int SizeBuckets  = 32,
   parameter int MeanFracBits = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           ev_valid,
   input  wire iqsc_pkg::event_type            ev_data,
   output logic                                ev_take,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [iqsc_pkg::StatWidth-1:0]      stat_value
);
   import iqsc_pkg::*;

   localparam int BktWidth = $clog2(SizeBuckets);
   localparam int HistSelMax = 11 + SizeBuckets;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CLEAR  = 7'b0000010,
      ST_HREAD  = 7'b0000100,
      ST_HWRITE = 7'b0001000,
      ST_FOLD   = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_DIV    = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   event_type              ev_ff, ev_in;
   logic                   run_started_ff, run_started_in;
   logic [TimeWidth-1:0]   start_time_ff, start_time_in, weight_time_ff, weight_time_in;
   logic [FileWidth-1:0]   files_now_ff, files_now_in, files_peak_ff, files_peak_in;
   logic [StatWidth-1:0]   files_area_ff, files_area_in;
   logic [JobsWidth-1:0]   jobs_peak_ff, jobs_peak_in;
   logic [BytesWidth-1:0]  bytes_peak_ff, bytes_peak_in;
   logic [StatWidth-1:0]   write_count_ff, write_count_in, borrowed_ff, borrowed_in;
   logic [StatWidth-1:0]   copied_ff, copied_in, fin_count_ff, fin_count_in;
   logic [StatWidth-1:0]   wait_total_ff, wait_total_in, run_total_ff, run_total_in;
   logic [TimeWidth-1:0]   wait_max_ff, wait_max_in, run_max_ff, run_max_in;
   logic [StatWidth-1:0]   prod_ff;
   logic                   prod_sat_ff;
   logic [FileWidth+TimeWidth-1:0] prod_in;
   logic [BktWidth-1:0]    clr_ff, clr_in, bkt;
   logic [StatWidth-1:0]   res_ff [2];
   logic [StatWidth-1:0]   res_data;
   logic                   res_push;
   logic                   rwp_ff, rrp_ff;
   logic [1:0]             rcnt_ff;
   logic                   div_start, div_done;
   logic [StatWidth-1:0]   div_num, div_den, div_quot;
   logic                   ram_we;
   logic [BktWidth-1:0]    ram_waddr, ram_raddr;
   logic [StatWidth-1:0]   ram_wdata, ram_rdata;
   logic [TimeWidth-1:0]   obs;
   logic [SelWidth-1:0]    hsel;

   // Results wait in a two-entry queue; a read only starts with a free slot.
   assign empty      = (rcnt_ff == 2'd0);
   assign stat_value = res_ff[rrp_ff];

   // Bucket: position of the highest set bit, clamped to the last bucket.
   always_comb begin
      bkt = '0;
      for (int i = 1; i < BytesWidth; i++) begin
         if (ev_ff.nbytes[i]) begin
            bkt = (i >= SizeBuckets - 1) ? BktWidth'(SizeBuckets - 1) : BktWidth'(i);
         end
      end
   end

   iqsc_ram #(.Width(StatWidth), .Depth(SizeBuckets)) u_hist (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr   (ram_raddr),
      .rd_data_ff(ram_rdata)
   );

   iqsc_divider #(.FracBits(MeanFracBits)) u_frac_div (
      .clock(clock), .reset(reset), .start(div_start && ev_ff.sel == SEL_FILES_MEAN),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
   );

   // Integer means share a second divider instance without fraction bits.
   logic int_done;
   logic [StatWidth-1:0] int_quot;
   iqsc_divider #(.FracBits(0)) u_int_div (
      .clock(clock), .reset(reset), .start(div_start && ev_ff.sel != SEL_FILES_MEAN),
      .num(div_num), .den(div_den), .done(int_done), .quot(int_quot)
   );

   // The fold product is formed from the word at the head of the input queue
   // while the back end idles, so it is registered by the time ST_FOLD adds it.
   assign prod_in = files_now_ff * span(weight_time_ff, ev_data.now);

   always_comb begin
      obs = run_started_ff ? span(start_time_ff, weight_time_ff) : '0;
      hsel = ev_ff.sel - SEL_HIST_BASE;
      div_num = (ev_ff.sel == SEL_FILES_MEAN) ? files_area_ff
              : (ev_ff.sel == SEL_WAIT_MEAN) ? wait_total_ff : run_total_ff;
      div_den = (ev_ff.sel == SEL_FILES_MEAN) ? {1'b0, obs} : fin_count_ff;

      state_in = state_ff;
      ev_in = ev_ff;
      run_started_in = run_started_ff;
      start_time_in = start_time_ff;
      weight_time_in = weight_time_ff;
      files_now_in = files_now_ff;
      files_peak_in = files_peak_ff;
      files_area_in = files_area_ff;
      jobs_peak_in = jobs_peak_ff;
      bytes_peak_in = bytes_peak_ff;
      write_count_in = write_count_ff;
      borrowed_in = borrowed_ff;
      copied_in = copied_ff;
      fin_count_in = fin_count_ff;
      wait_total_in = wait_total_ff;
      run_total_in = run_total_ff;
      wait_max_in = wait_max_ff;
      run_max_in = run_max_ff;
      clr_in = clr_ff;
      ev_take = 1'b0;
      res_push = 1'b0;
      res_data = '0;
      div_start = 1'b0;
      ram_we = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_raddr = bkt;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BktWidth'(SizeBuckets - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ev_valid && (ev_data.op != OP_READ || rcnt_ff != 2'd2)) begin
               ev_take = 1'b1;
               ev_in = ev_data;
               unique case (ev_data.op)
                  OP_POST:   state_in = ST_HREAD;
                  OP_FINISH: state_in = ST_IDLE;
                  default:   state_in = ST_FOLD;
               endcase
               if (ev_data.op == OP_FINISH && ev_data.nonempty) begin
                  fin_count_in  = sat_add(fin_count_ff, 64'd1);
                  wait_total_in = sat_add(wait_total_ff, {1'b0, ev_data.wait_ns});
                  run_total_in  = sat_add(run_total_ff, {1'b0, ev_data.run_ns});
                  if (ev_data.wait_ns > wait_max_ff) wait_max_in = ev_data.wait_ns;
                  if (ev_data.run_ns > run_max_ff) run_max_in = ev_data.run_ns;
               end
            end
         end
         ST_HREAD: begin
            // Post: peaks and start; the histogram read is under way.
            if (!run_started_ff) begin
               run_started_in = 1'b1;
               start_time_in = ev_ff.now;
               weight_time_in = ev_ff.now;
            end
            if (ev_ff.jobs > jobs_peak_ff) jobs_peak_in = ev_ff.jobs;
            if (ev_ff.bytes > bytes_peak_ff) bytes_peak_in = ev_ff.bytes;
            if (ev_ff.nonempty) begin
               write_count_in = sat_add(write_count_ff, 64'd1);
               if (ev_ff.borrowed)
                  borrowed_in = sat_add(borrowed_ff, {16'd0, ev_ff.nbytes});
               else
                  copied_in = sat_add(copied_ff, {16'd0, ev_ff.nbytes});
               state_in = ST_HWRITE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HWRITE: begin
            ram_we = 1'b1;
            ram_waddr = bkt;
            ram_wdata = sat_add(ram_rdata, 64'd1);
            state_in = ST_IDLE;
         end
         ST_FOLD: begin
            // Product was registered last cycle; add it now.
            state_in = ST_READ;
            files_area_in = prod_sat_ff ? {StatWidth{1'b1}} : sat_add(files_area_ff, prod_ff);
            weight_time_in = ev_ff.now;
            if (ev_ff.op == OP_FILES) begin
               files_now_in = ev_ff.files;
               if (ev_ff.files > files_peak_ff) files_peak_in = ev_ff.files;
               state_in = ST_IDLE;
            end else if ({1'b0, ev_ff.sel} < 7'(HistSelMax) && ev_ff.sel >= SEL_HIST_BASE) begin
               ram_raddr = BktWidth'(hsel);
            end
         end
         ST_READ: begin
            ram_raddr = BktWidth'(hsel);
            state_in = ST_IDLE;
            res_push = 1'b1;
            if (ev_ff.sel == SEL_FILES_MEAN || ev_ff.sel == SEL_WAIT_MEAN ||
                ev_ff.sel == SEL_RUN_MEAN) begin
               if (div_den != '0) begin
                  res_push = 1'b0;
                  div_start = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (ev_ff.sel >= SEL_HIST_BASE) begin
               if ({1'b0, ev_ff.sel} < 7'(HistSelMax)) res_data = ram_rdata;
            end else begin
               unique case (ev_ff.sel)
                  SEL_FILES_PEAK: res_data = 64'(files_peak_ff);
                  SEL_JOBS_PEAK:  res_data = 64'(jobs_peak_ff);
                  SEL_BYTES_PEAK: res_data = 64'(bytes_peak_ff);
                  SEL_WRITES:     res_data = write_count_ff;
                  SEL_BORROWED:   res_data = borrowed_ff;
                  SEL_COPIED:     res_data = copied_ff;
                  SEL_WAIT_MAX:   res_data = 64'(wait_max_ff);
                  SEL_RUN_MAX:    res_data = 64'(run_max_ff);
                  default:        res_data = '0;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done || int_done) begin
               res_push = 1'b1;
               res_data = div_done ? div_quot : int_quot;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      prod_ff <= prod_in[StatWidth-1:0];
      prod_sat_ff <= prod_in[FileWidth+TimeWidth-1:StatWidth] != '0;
      if (res_push) begin
         res_ff[rwp_ff] <= res_data;
      end
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         run_started_ff <= 1'b0;
         start_time_ff <= '0;
         weight_time_ff <= '0;
         files_now_ff <= '0;
         files_peak_ff <= '0;
         files_area_ff <= '0;
         jobs_peak_ff <= '0;
         bytes_peak_ff <= '0;
         write_count_ff <= '0;
         borrowed_ff <= '0;
         copied_ff <= '0;
         fin_count_ff <= '0;
         wait_total_ff <= '0;
         run_total_ff <= '0;
         wait_max_ff <= '0;
         run_max_ff <= '0;
         rwp_ff <= 1'b0;
         rrp_ff <= 1'b0;
         rcnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         run_started_ff <= run_started_in;
         start_time_ff <= start_time_in;
         weight_time_ff <= weight_time_in;
         files_now_ff <= files_now_in;
         files_peak_ff <= files_peak_in;
         files_area_ff <= files_area_in;
         jobs_peak_ff <= jobs_peak_in;
         bytes_peak_ff <= bytes_peak_in;
         write_count_ff <= write_count_in;
         borrowed_ff <= borrowed_in;
         copied_ff <= copied_in;
         fin_count_ff <= fin_count_in;
         wait_total_ff <= wait_total_in;
         run_total_ff <= run_total_in;
         wait_max_ff <= wait_max_in;
         run_max_ff <= run_max_in;
         if (res_push) rwp_ff <= ~rwp_ff;
         if (pop && !empty) rrp_ff <= ~rrp_ff;
         rcnt_ff <= rcnt_ff + {1'b0, res_push} - {1'b0, pop && !empty};
      end
   end
endmodule
`default_nettype wire
